FILE: design/sqe_pkg.sv
// Shared types and constants of the stroke quad expander.
// Used by sqe_ctrl, sqe_dpath and stroke_quad_expander; no dependencies.
package sqe_pkg;

    localparam int COORD_BITS = 24;
    localparam int INDEX_BITS = 32;
    localparam int COLOR_BITS = 32;
    localparam int WIDTH_BITS = 16;
    localparam int OFF_BITS   = 18;
    localparam int QUO_BITS   = 17;
    localparam int ROOT_STEPS = 32;
    localparam int ITEMS      = 10;
    localparam int VERTS      = 4;

    localparam logic [1:0] OP_LINE  = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_RECT  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    typedef struct packed {
        logic       capture;
        logic       sq_load;
        logic       root_step;
        logic       mul_y;
        logic       mul_load;
        logic       div_load;
        logic       div_step;
        logic       store_x;
        logic       store_y;
        logic       emit_load;
        logic [3:0] emit_idx;
    } sqe_cmd_t;

    typedef struct packed {
        logic zero_len;
    } sqe_sts_t;

    // Corner order of the six indices of a quad.
    function automatic logic [1:0] idx_pattern(input logic [2:0] k);
        logic [1:0] p;
        unique case (k)
            3'd0:    p = 2'd0;
            3'd1:    p = 2'd1;
            3'd2:    p = 2'd2;
            3'd3:    p = 2'd1;
            3'd4:    p = 2'd3;
            3'd5:    p = 2'd2;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

FILE: design/sqe_ctrl.sv
// Sequencer of the stroke quad expander: square root, two divisions, emission.
// Depends on sqe_pkg.
module sqe_ctrl
    import sqe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_op,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  sqe_sts_t   sts,
    output sqe_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROOT, S_MULX, S_LDX, S_DIVX,
        S_MULY, S_LDY, S_DIVY, S_STY, S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       valid_reg, valid_next;
    logic       accept, out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !out_ready;
        cmd        = '0;
        cmd.emit_idx = cnt_reg[3:0];
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    unique case (in_op)
                        OP_LINE:  state_next = S_SQ;
                        OP_POINT: state_next = S_EMIT;
                        OP_RECT:  state_next = S_EMIT;
                        OP_NONE:  state_next = S_IDLE;
                    endcase
                end
            end
            S_SQ:
            begin
                cmd.sq_load = 1'b1;
                state_next  = sts.zero_len ? S_EMIT : S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_LDX;
            end
            S_LDX:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIVX;
            end
            S_DIVX:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_BITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_MULY;
                end
            end
            S_MULY:
            begin
                cmd.store_x  = 1'b1;
                cmd.mul_y    = 1'b1;
                cmd.mul_load = 1'b1;
                state_next   = S_LDY;
            end
            S_LDY:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIVY;
            end
            S_DIVY:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_BITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_STY;
                end
            end
            S_STY:
            begin
                cmd.store_y = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit_load = 1'b1;
                    valid_next    = 1'b1;
                    cnt_next      = cnt_reg + 5'd1;
                    if (cnt_reg == 5'(ITEMS - 1))
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: design/sqe_dpath.sv
// Datapath of the stroke quad expander: operand store, root and divide units,
// vertex and index formation, output word register. Depends on sqe_pkg.
module sqe_dpath
    import sqe_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sqe_cmd_t                      cmd,
    input  logic [1:0]                    in_op,
    input  logic signed [COORD_BITS-1:0]  in_fx,
    input  logic signed [COORD_BITS-1:0]  in_fy,
    input  logic signed [COORD_BITS-1:0]  in_sx,
    input  logic signed [COORD_BITS-1:0]  in_sy,
    input  logic [COLOR_BITS-1:0]         in_ca,
    input  logic [COLOR_BITS-1:0]         in_cb,
    input  logic [COLOR_BITS-1:0]         in_cc,
    input  logic [COLOR_BITS-1:0]         in_cd,
    input  logic [WIDTH_BITS-1:0]         in_w,
    output sqe_sts_t                      sts,
    output logic                          out_kind,
    output logic signed [COORD_BITS-1:0]  out_x,
    output logic signed [COORD_BITS-1:0]  out_y,
    output logic [COLOR_BITS-1:0]         out_color,
    output logic [INDEX_BITS-1:0]         out_index,
    output logic                          out_last
);

    localparam int MAG_BITS  = COORD_BITS;
    localparam int SUM_BITS  = 2 * MAG_BITS + 1;
    localparam int PROD_BITS = MAG_BITS + WIDTH_BITS;
    localparam int NUM_BITS  = PROD_BITS + 8;
    localparam int DEN_BITS  = 33;

    logic [1:0]                   op_reg;
    logic signed [COORD_BITS-1:0] fx_reg, fy_reg, sx_reg, sy_reg;
    logic [COLOR_BITS-1:0]        ca_reg, cb_reg, cc_reg, cd_reg;
    logic [WIDTH_BITS-1:0]        w_reg;
    logic [MAG_BITS-1:0]          ax_reg, ay_reg;
    logic                         negx_reg, negy_reg;
    logic [63:0]                  rem_reg, root_reg, bit_reg;
    logic [PROD_BITS-1:0]         prod_reg;
    logic [DEN_BITS:0]            drem_reg;
    logic [QUO_BITS-1:0]          num_reg, quo_reg;
    logic signed [OFF_BITS-1:0]   offx_reg, offy_reg;
    logic [INDEX_BITS-1:0]        total_reg;
    logic                         kind_reg, last_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic [COLOR_BITS-1:0]        color_reg;
    logic [INDEX_BITS-1:0]        index_reg;

    logic signed [COORD_BITS:0]   dx, dy;
    logic [SUM_BITS-1:0]          sq_sum;
    logic [63:0]                  trial;
    logic [NUM_BITS-1:0]          num;
    logic [DEN_BITS-1:0]          den;
    logic [DEN_BITS:0]            dtrial;
    logic signed [OFF_BITS-1:0]   q_pos, q_neg, h_pos;
    logic [1:0]                   k;
    logic                         top, odd;
    logic signed [COORD_BITS-1:0] bx, by;
    logic signed [OFF_BITS-1:0]   addx, addy;
    logic signed [COORD_BITS+1:0] sumx, sumy;
    logic signed [COORD_BITS+1:0] cmax, cmin;
    logic [COLOR_BITS-1:0]        vcol;

    assign dx = $signed({in_sx[COORD_BITS-1], in_sx}) - $signed({in_fx[COORD_BITS-1], in_fx});
    assign dy = $signed({in_sy[COORD_BITS-1], in_sy}) - $signed({in_fy[COORD_BITS-1], in_fy});

    assign sq_sum = SUM_BITS'(ax_reg * ax_reg) + SUM_BITS'(ay_reg * ay_reg);
    assign trial  = root_reg + bit_reg;
    assign num    = {1'b0, prod_reg, 7'b0} + NUM_BITS'(root_reg[31:0]);
    assign den    = {root_reg[31:0], 1'b0};
    assign dtrial = {drem_reg[DEN_BITS-1:0], num_reg[QUO_BITS-1]};
    assign q_pos  = $signed({1'b0, quo_reg});
    assign q_neg  = -q_pos;
    assign h_pos  = $signed(OFF_BITS'((WIDTH_BITS+1)'(w_reg) + 17'd1) >>> 1);

    assign sts.zero_len = (ax_reg == '0) && (ay_reg == '0);

    // Corner selection: bit 0 picks right, bit 1 picks bottom.
    assign k   = cmd.emit_idx[1:0];
    assign odd = k[0];
    assign top = !k[1];

    always_comb
    begin
        bx   = odd ? sx_reg : fx_reg;
        by   = odd ? sy_reg : fy_reg;
        addx = '0;
        addy = '0;
        vcol = odd ? cb_reg : ca_reg;
        unique case (op_reg)
            OP_LINE:
            begin
                addx = top ? offy_reg : -offy_reg;
                addy = top ? -offx_reg : offx_reg;
            end
            OP_POINT:
            begin
                bx   = fx_reg;
                by   = fy_reg;
                addx = odd ? h_pos : -h_pos;
                addy = top ? h_pos : -h_pos;
                vcol = ca_reg;
            end
            OP_RECT, OP_NONE:
            begin
                by = top ? fy_reg : sy_reg;
                unique case (k)
                    2'd0: vcol = ca_reg;
                    2'd1: vcol = cb_reg;
                    2'd2: vcol = cc_reg;
                    2'd3: vcol = cd_reg;
                endcase
            end
        endcase
        sumx = (COORD_BITS+2)'(bx) + (COORD_BITS+2)'(addx);
        sumy = (COORD_BITS+2)'(by) + (COORD_BITS+2)'(addy);
        cmax = (COORD_BITS+2)'({1'b0, {(COORD_BITS-1){1'b1}}});
        cmin = -cmax - 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else if (cmd.emit_load && cmd.emit_idx == 4'(ITEMS - 1))
            total_reg <= total_reg + INDEX_BITS'(VERTS);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_op;
            fx_reg   <= in_fx;
            fy_reg   <= in_fy;
            sx_reg   <= in_sx;
            sy_reg   <= in_sy;
            ca_reg   <= in_ca;
            cb_reg   <= in_cb;
            cc_reg   <= in_cc;
            cd_reg   <= in_cd;
            w_reg    <= in_w;
            negx_reg <= dx[COORD_BITS];
            negy_reg <= dy[COORD_BITS];
            ax_reg   <= MAG_BITS'(dx[COORD_BITS] ? -dx : dx);
            ay_reg   <= MAG_BITS'(dy[COORD_BITS] ? -dy : dy);
            offx_reg <= '0;
            offy_reg <= '0;
        end
        if (cmd.sq_load)
        begin
            rem_reg  <= 64'({sq_sum, 14'b0});
            root_reg <= '0;
            bit_reg  <= 64'h4000_0000_0000_0000;
        end
        if (cmd.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.mul_load)
            prod_reg <= (cmd.mul_y ? ay_reg : ax_reg) * w_reg;
        if (cmd.div_load)
        begin
            drem_reg <= (DEN_BITS+1)'(num[NUM_BITS-1:QUO_BITS]);
            num_reg  <= num[QUO_BITS-1:0];
            quo_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            if (dtrial >= {1'b0, den})
            begin
                drem_reg <= dtrial - {1'b0, den};
                quo_reg  <= {quo_reg[QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dtrial;
                quo_reg  <= {quo_reg[QUO_BITS-2:0], 1'b0};
            end
            num_reg <= num_reg << 1;
        end
        if (cmd.store_x)
            offx_reg <= negx_reg ? q_neg : q_pos;
        if (cmd.store_y && op_reg == OP_LINE && !sts.zero_len)
            offy_reg <= negy_reg ? q_neg : q_pos;
        if (cmd.emit_load)
        begin
            if (cmd.emit_idx < 4'(VERTS))
            begin
                kind_reg  <= KIND_VERTEX;
                x_reg     <= (sumx > cmax) ? cmax[COORD_BITS-1:0] :
                             (sumx < cmin) ? cmin[COORD_BITS-1:0] : sumx[COORD_BITS-1:0];
                y_reg     <= (sumy > cmax) ? cmax[COORD_BITS-1:0] :
                             (sumy < cmin) ? cmin[COORD_BITS-1:0] : sumy[COORD_BITS-1:0];
                color_reg <= vcol;
                index_reg <= '0;
            end
            else
            begin
                kind_reg  <= KIND_INDEX;
                x_reg     <= '0;
                y_reg     <= '0;
                color_reg <= '0;
                index_reg <= total_reg
                           + INDEX_BITS'(idx_pattern(3'(cmd.emit_idx - 4'(VERTS))));
            end
            last_reg <= (cmd.emit_idx == 4'(ITEMS - 1));
        end
    end

    assign out_kind  = kind_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_color = color_reg;
    assign out_index = index_reg;
    assign out_last  = last_reg;

endmodule

FILE: design/stroke_quad_expander.sv
// Stroke quad expander top level: one primitive in, ten words out.
// Points and rectangles go straight to emission after acceptance; lines first pass
// through the square, the root steps, then per offset a multiply, a divide load and the
// divide steps, and the store. A new primitive is taken only after the last word of the
// previous one is loaded; emission waits on m_tready, lines on the root and divide units.
// Reset (rst_n, asynchronous, active low) clears the sequencer, the output
// valid and the running vertex count; operation 3 words are dropped.
module stroke_quad_expander
    import sqe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, second_x, second_y, color_a, color_b, color_c,
    // color_d, stroke_width (lowest bits first)
    input  logic [239:0] s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertex_x, vertex_y, vertex_color, index_value (lowest bits first)
    output logic [111:0] m_tdata,
    // item_kind
    output logic         m_tuser,
    // last_item
    output logic         m_tlast
);

    sqe_cmd_t cmd;
    sqe_sts_t sts;
    logic signed [COORD_BITS-1:0] out_x, out_y;
    logic [COLOR_BITS-1:0]        out_color;
    logic [INDEX_BITS-1:0]        out_index;

    // Sequence the work: capture, root, divide, then emit ten words.
    sqe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold operands and form each output word.
    sqe_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_op     (s_tuser),
        .in_fx     (s_tdata[23:0]),
        .in_fy     (s_tdata[47:24]),
        .in_sx     (s_tdata[71:48]),
        .in_sy     (s_tdata[95:72]),
        .in_ca     (s_tdata[127:96]),
        .in_cb     (s_tdata[159:128]),
        .in_cc     (s_tdata[191:160]),
        .in_cd     (s_tdata[223:192]),
        .in_w      (s_tdata[239:224]),
        .sts       (sts),
        .out_kind  (m_tuser),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_color (out_color),
        .out_index (out_index),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_index, out_color, out_y, out_x};

endmodule

FILE: sim/quad_predictor.sv
// Scoreboard for the stroke quad expander: predicts the ten output words of
// each accepted primitive and checks the output stream. Depends on sqe_pkg.
`timescale 1ns / 1ps

class quad_predictor;

    typedef struct {
        logic        kind;
        logic [23:0] vx;
        logic [23:0] vy;
        logic [31:0] color;
        logic [31:0] index;
        logic        last;
    } quad_word_t;

    quad_word_t  expected_words[$];
    logic [31:0] vertex_total;
    int          failures;

    function new();
        vertex_total = '0;
        failures     = 0;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [23:0] clamp_coord(longint v);
        if (v > 64'sd8388607)
            return 24'h7FFFFF;
        if (v < -64'sd8388608)
            return 24'h800000;
        return v[23:0];
    endfunction

    // Offset magnitude |d|*w/(2*len), rounded half up, carrying the delta's sign.
    function automatic longint half_offset(longint unsigned mag, bit neg,
                                           longint unsigned w, longint unsigned len7);
        longint unsigned q;
        q = (2 * mag * w * 64 + len7) / (2 * len7);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function void note_primitive(logic [1:0] op, logic [239:0] d);
        logic signed [23:0] fx24, fy24, sx24, sy24;
        longint             fx, fy, sx, sy, dx, dy, ox, oy, h;
        longint unsigned    ax, ay, w, len7;
        longint             vx[4], vy[4];
        logic [31:0]        vc[4];
        logic [31:0]        ca, cb, cc, cd;
        logic [1:0]         corner;
        quad_word_t         wd;
        fx24 = d[23:0];
        fy24 = d[47:24];
        sx24 = d[71:48];
        sy24 = d[95:72];
        fx = fx24;
        fy = fy24;
        sx = sx24;
        sy = sy24;
        ca = d[127:96];
        cb = d[159:128];
        cc = d[191:160];
        cd = d[223:192];
        w  = d[239:224];
        case (op)
            sqe_pkg::OP_LINE:
            begin
                dx = sx - fx;
                dy = sy - fy;
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                ox = 0;
                oy = 0;
                while (ax >= (64'd1 << 24) || ay >= (64'd1 << 24))
                begin
                    ax = ax >> 1;
                    ay = ay >> 1;
                end
                // a zero-length line keeps zero offsets
                if (ax != 0 || ay != 0)
                begin
                    len7 = int_sqrt((ax * ax + ay * ay) << 14);
                    ox = half_offset(ax, dx < 0, w, len7);
                    oy = half_offset(ay, dy < 0, w, len7);
                end
                vx[0] = fx + oy; vy[0] = fy - ox; vc[0] = ca;
                vx[1] = sx + oy; vy[1] = sy - ox; vc[1] = cb;
                vx[2] = fx - oy; vy[2] = fy + ox; vc[2] = ca;
                vx[3] = sx - oy; vy[3] = sy + ox; vc[3] = cb;
            end
            sqe_pkg::OP_POINT:
            begin
                h = (w + 1) >> 1;
                vx[0] = fx - h; vy[0] = fy + h;
                vx[1] = fx + h; vy[1] = fy + h;
                vx[2] = fx - h; vy[2] = fy - h;
                vx[3] = fx + h; vy[3] = fy - h;
                vc[0] = ca; vc[1] = ca; vc[2] = ca; vc[3] = ca;
            end
            sqe_pkg::OP_RECT:
            begin
                vx[0] = fx; vy[0] = fy; vc[0] = ca;
                vx[1] = sx; vy[1] = fy; vc[1] = cb;
                vx[2] = fx; vy[2] = sy; vc[2] = cc;
                vx[3] = sx; vy[3] = sy; vc[3] = cd;
            end
            default:
                return;   // unknown operation: no words, count untouched
        endcase
        for (int k = 0; k < 4; k++)
        begin
            wd.kind  = sqe_pkg::KIND_VERTEX;
            wd.vx    = clamp_coord(vx[k]);
            wd.vy    = clamp_coord(vy[k]);
            wd.color = vc[k];
            wd.index = '0;
            wd.last  = 1'b0;
            expected_words.insert(expected_words.size(), wd);
        end
        for (int k = 0; k < 6; k++)
        begin
            corner   = sqe_pkg::idx_pattern(k[2:0]);
            wd.kind  = sqe_pkg::KIND_INDEX;
            wd.vx    = '0;
            wd.vy    = '0;
            wd.color = '0;
            wd.index = vertex_total + corner;
            wd.last  = (k == 5);
            expected_words.insert(expected_words.size(), wd);
        end
        vertex_total = vertex_total + 32'd4;
    endfunction

    function void check_word(logic kind, logic [111:0] d, logic last);
        quad_word_t e;
        if (expected_words.size() == 0)
        begin
            $error("unexpected output word %h", d);
            failures++;
            return;
        end
        e = expected_words.pop_front();
        if (kind !== e.kind)
        begin
            $error("item_kind expected %0d actual %0d", e.kind, kind);
            failures++;
        end
        if (d[23:0] !== e.vx)
        begin
            $error("vertex_x expected %h actual %h", e.vx, d[23:0]);
            failures++;
        end
        if (d[47:24] !== e.vy)
        begin
            $error("vertex_y expected %h actual %h", e.vy, d[47:24]);
            failures++;
        end
        if (d[79:48] !== e.color)
        begin
            $error("vertex_color expected %h actual %h", e.color, d[79:48]);
            failures++;
        end
        if (d[111:80] !== e.index)
        begin
            $error("index_value expected %h actual %h", e.index, d[111:80]);
            failures++;
        end
        if (last !== e.last)
        begin
            $error("last_item expected %0d actual %0d", e.last, last);
            failures++;
        end
    endfunction

endclass

FILE: sim/tb_stroke_quad_expander.sv
// Testbench top for stroke_quad_expander: directed and random primitives with
// random back-pressure on both sides. Depends on sqe_pkg and quad_predictor.
`timescale 1ns / 1ps

module tb_stroke_quad_expander;
    import sqe_pkg::*;

    localparam int STALL_LIMIT = 20000;  // idle cycles before giving up
    localparam int DRAIN_WAIT  = 120;    // extra wait after the final drain

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [239:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    quad_predictor quads;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            stall_cycles;

    stroke_quad_expander uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: decide readiness at each falling edge.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Check accepted output words at the rising edge; watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                quads.check_word(m_tuser, m_tdata, m_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Offer one primitive, idling at random first; hold it until accepted.
    task automatic send_primitive(input logic [1:0] op, input logic [23:0] fx,
                                  input logic [23:0] fy, input logic [23:0] sx,
                                  input logic [23:0] sy, input logic [31:0] ca,
                                  input logic [31:0] cb, input logic [31:0] cc,
                                  input logic [31:0] cd, input logic [15:0] w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {w, cd, cc, cb, ca, sy, sx, fy, fx};
        do
            @(posedge clk);
        while (!s_tready);
        quads.note_primitive(op, s_tdata);
    endtask

    task automatic send_random();
        logic [1:0]  op;
        logic [23:0] fx, fy, sx, sy;
        logic [15:0] w;
        int          pick;
        pick = $urandom_range(99);
        op   = (pick < 5) ? OP_NONE : 2'($urandom_range(2));
        fx   = $urandom;
        fy   = $urandom;
        if (pick < 40)
        begin
            // short strokes near the start point
            sx = fx + 24'($urandom_range(8191)) - 24'd4096;
            sy = fy + 24'($urandom_range(8191)) - 24'd4096;
        end
        else
        begin
            sx = $urandom;
            sy = $urandom;
        end
        w = (pick % 7 == 0) ? 16'hFFFF : 16'($urandom);
        send_primitive(op, fx, fy, sx, sy, $urandom, $urandom, $urandom, $urandom, w);
    endtask

    // Hold the sender until every expected word has arrived.
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (quads.expected_words.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        quads         = new();
        send_idle_pct = 20;
        recv_idle_pct = 70;
        stall_cycles  = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_LINE;
        m_tready      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every operation, extremes, zero-length, axis lines, saturation.
        send_primitive(OP_LINE, 24'd1000, 24'd2000, 24'd1000, 24'd2000,
                       32'h11111111, 32'h22222222, 0, 0, 16'd512);
        send_primitive(OP_LINE, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                       32'hFFFFFFFF, 32'h0, 0, 0, 16'hFFFF);
        send_primitive(OP_LINE, 24'h7FFFFF, 24'h0, 24'h800000, 24'h0,
                       32'h0, 32'hFFFFFFFF, 0, 0, 16'hFFFF);
        send_primitive(OP_LINE, 24'h0, 24'h800000, 24'h0, 24'h7FFFFF,
                       32'hA5A5A5A5, 32'h5A5A5A5A, 0, 0, 16'd256);
        send_primitive(OP_LINE, 24'd0, 24'd0, 24'd300, 24'd400, 32'h1, 32'h2, 0, 0, 16'd0);
        send_primitive(OP_LINE, 24'd10, 24'd10, 24'd11, 24'd10, 32'h3, 32'h4, 0, 0, 16'd1);
        send_primitive(OP_LINE, 24'h7FFF00, 24'h7FFF00, 24'h7FFFFF, 24'h7FFF00,
                       32'h5, 32'h6, 0, 0, 16'hFFFF);
        send_primitive(OP_POINT, 24'h7FFFFF, 24'h800000, 0, 0,
                       32'hDEADBEEF, 0, 0, 0, 16'hFFFF);
        send_primitive(OP_POINT, 24'h800000, 24'h7FFFFF, 0, 0,
                       32'hCAFEF00D, 0, 0, 0, 16'd1);
        send_primitive(OP_POINT, 24'd0, 24'd0, 0, 0, 32'h0, 0, 0, 0, 16'd0);
        send_primitive(OP_POINT, 24'd500, 24'hFFFF00, 0, 0, 32'h12345678, 0, 0, 0, 16'd3);
        send_primitive(OP_RECT, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                       32'h01020304, 32'h05060708, 32'h090A0B0C, 32'h0D0E0F10, 16'hFFFF);
        send_primitive(OP_RECT, 24'd100, 24'd200, 24'd50, 24'd20,
                       32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd0);
        send_primitive(OP_NONE, 24'd1, 24'd2, 24'd3, 24'd4, 32'h1, 32'h2, 32'h3, 32'h4, 16'd5);
        send_primitive(OP_RECT, 24'd0, 24'd0, 24'd0, 24'd0, 0, 0, 0, 0, 16'd0);
        drain();

        // Random: three idling phases, draining between them.
        for (int n = 0; n < 60; n++)
            send_random();
        drain();
        send_idle_pct = 70;
        recv_idle_pct = 20;
        for (int n = 0; n < 55; n++)
            send_random();
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 55; n++)
            send_random();
        drain();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (quads.failures == 0 && quads.expected_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
